FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// clocked check that also holds while reset is held
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: hdl/fwdf_pkg.sv
// types and constants of the decimal formatter
package fwdf_pkg;

    localparam int VALUE_W   = 31;
    localparam int COUNT_W   = 4;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 6;
    localparam int BIT_CNT_W = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digit_count;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } out_t;

    // control from the sequencer to every digit cell
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

FILE: hdl/fwdf_bcd_cell.sv
// one bcd digit cell of the shift-and-add-three chain
module fwdf_bcd_cell (
    input  logic                        clk,
    input  fwdf_pkg::cell_ctrl_t        ctrl,
    input  logic                        carry_in,
    output logic                        carry_out,
    output logic [fwdf_pkg::DIGIT_W-1:0] digit
);
    import fwdf_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] adjusted;
    logic [DIGIT_W-1:0] digit_next;

    // add three when the digit would pass nine after doubling
    assign adjusted   = (digit_reg >= DIGIT_W'(5)) ? digit_reg + DIGIT_W'(3) : digit_reg;
    assign digit_next = {adjusted[DIGIT_W-2:0], carry_in};
    assign carry_out  = adjusted[DIGIT_W-1];
    assign digit      = digit_reg;

    // digit storage
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            digit_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

FILE: hdl/fixed_width_decimal_formatter_unit.sv
// decimal formatter top level: sequencer, bcd cell chain and output register
// first character: the convert state shifts all 31 value bits into the cell chain,
// then the emit state loads it into the output register; after that, one character
// per cycle while out_ready is high; a new item is taken only in the idle state
// reset: rst_n asynchronous, clears the sequencer and the output valid
module fixed_width_decimal_formatter_unit #(
    parameter int MAX_DIGITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fwdf_pkg::in_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fwdf_pkg::out_t out_data
);
    import fwdf_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic                 out_valid_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [VALUE_W-1:0]   value_reg;
    out_t                 out_data_reg;

    logic                 in_fire;
    logic                 emit_load;
    logic [COUNT_W-1:0]   sat_count;
    cell_ctrl_t           cell_ctrl;
    logic                 carry [MAX_DIGITS];
    logic [DIGIT_W-1:0]   digit [MAX_DIGITS];

    // handshake and count saturation
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign sat_count = (in_data.digit_count > COUNT_W'(MAX_DIGITS)) ?
                       COUNT_W'(MAX_DIGITS) : in_data.digit_count;

    assign cell_ctrl.clear = in_fire;
    assign cell_ctrl.shift = (state_reg == ST_CONVERT);

    // bcd cell chain, binary bits enter at the least significant digit
    assign carry[0] = value_reg[VALUE_W-1];

    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_cell
        if (g == MAX_DIGITS - 1)
        begin : g_top
            fwdf_bcd_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .carry_in  (carry[g]),
                .carry_out (),
                .digit     (digit[g])
            );
        end
        else
        begin : g_mid
            fwdf_bcd_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .carry_in  (carry[g]),
                .carry_out (carry[g+1]),
                .digit     (digit[g])
            );
        end
    end

    // sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_fire && (sat_count != '0))
                    begin
                        state_reg   <= ST_CONVERT;
                        bit_cnt_reg <= BIT_CNT_W'(VALUE_W - 1);
                        idx_reg     <= IDX_W'(sat_count - COUNT_W'(1));
                    end
                end
                ST_CONVERT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_valid_reg <= 1'b1;
                        if (idx_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // binary shift register and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            value_reg <= in_data.value;
        end
        else if (state_reg == ST_CONVERT)
        begin
            value_reg <= {value_reg[VALUE_W-2:0], 1'b0};
        end

        if (emit_load)
        begin
            out_data_reg.character <= ASCII_ZERO + CHAR_W'(digit[idx_reg]);
            out_data_reg.last      <= (idx_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hdl/fwdf_checker.sv
// port-level checks of the decimal formatter and their bind
`include "assert_macros.svh"

module fwdf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input fwdf_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input fwdf_pkg::out_t out_data
);
    import fwdf_pkg::*;

    // only decimal digit characters leave the block
    `ASSERT_CLK(a_char_range, out_valid |-> (out_data.character >= 6'd48 && out_data.character <= 6'd57), "character outside digit range")

    // a nonempty item keeps the input closed while it converts
    `ASSERT_CLK(a_busy_after_item, (in_valid && in_ready && in_data.digit_count != '0) |=> !in_ready, "input open during conversion")

    // characters of one run follow without gaps
    `ASSERT_CLK(a_run_contiguous, (out_valid && out_ready && !out_data.last) |=> out_valid, "gap inside a character run")

    // a stalled character holds
    `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "stalled character changed")

    // no output while reset is held
    `ASSERT_CLK_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind fixed_width_decimal_formatter_unit fwdf_checker u_fwdf_checker (.*);

FILE: verif/fixed_width_decimal_formatter_unit_tb.sv
// testbench of the fixed-width decimal formatter: directed, saturated-count, steady, back-pressure and random items
`timescale 1ns / 1ps

module fixed_width_decimal_formatter_unit_tb;

    import fwdf_pkg::*;

    localparam int MAX_DIGITS   = 10;
    localparam int DECIMAL_BASE = 10;
    localparam int IDLE_PCT     = 22;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    // characters still owed by the block, oldest first
    out_t expected_chars[$];
    out_t want_char;
    int   error_count = 0;
    bit   steady;
    int   hold_requests;
    int   hold_served;
    int   held_cycles;

    fixed_width_decimal_formatter_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // decimal digits of the value modulo ten to the count, count capped at MAX_DIGITS, most significant first
    task automatic predict_decimal(input logic [VALUE_W-1:0] value,
                                   input logic [COUNT_W-1:0] count);
        int unsigned rest;
        int unsigned width;
        int unsigned digits[MAX_DIGITS];
        int          i;
        out_t        ch;
        rest  = 32'(value);
        width = (count > MAX_DIGITS) ? MAX_DIGITS : 32'(count);
        for (i = 0; i < MAX_DIGITS; i++)
        begin
            digits[i] = rest % DECIMAL_BASE;
            rest      = rest / DECIMAL_BASE;
        end
        for (i = 0; i < width; i++)
        begin
            ch.character = CHAR_W'(ASCII_ZERO + digits[width - 1 - i]);
            ch.last      = (i == width - 1);
            expected_chars.push_back(ch);
        end
    endtask

    // offer one number, with random idle cycles ahead of it unless steady is set, and wait for the transfer
    task automatic offer_number(input logic [VALUE_W-1:0] value,
                                input logic [COUNT_W-1:0] count);
        in_t item;
        item.value       = value;
        item.digit_count = count;
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_decimal(value, count);
    endtask

    // values weighted towards powers of ten and the top of the range
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned power;
        int          k;
        case ($urandom_range(3))
            0: return VALUE_W'($urandom());
            1: return VALUE_W'($urandom_range(999));
            2:
            begin
                power = 1;
                for (k = $urandom_range(9); k > 0; k--)
                    power = power * DECIMAL_BASE;
                return VALUE_W'(power + $urandom_range(2) - 1);
            end
            default: return VALUE_W'($urandom_range(VALUE_MAX, VALUE_MAX - 500000));
        endcase
    endfunction

    // mostly legal counts, some zero and some above the maximum
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        else if (roll < 20)
            return COUNT_W'($urandom_range(15, MAX_DIGITS + 1));
        else
            return COUNT_W'($urandom_range(MAX_DIGITS, 1));
    endfunction

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, what);
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        out_ready   = 1'b0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                out_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++)
                    @(posedge clk);
            end
            else
            begin
                out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare each output transfer with the oldest expected character
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                note_error($sformatf("unexpected character 0x%02h last %0b",
                                     out_data.character, out_data.last));
            end
            else
            begin
                want_char = expected_chars.pop_front();
                if (out_data.character !== want_char.character)
                    note_error($sformatf("character expected 0x%02h got 0x%02h",
                                         want_char.character, out_data.character));
                if (out_data.last !== want_char.last)
                    note_error($sformatf("last expected %0b got %0b",
                                         want_char.last, out_data.last));
            end
        end
    end

    // extremes of both fields, padding and dropped high digits
    task automatic test_directed_edges();
        offer_number('0, '0);
        offer_number('0, COUNT_W'(1));
        offer_number('0, COUNT_W'(MAX_DIGITS));
        offer_number(VALUE_MAX, COUNT_W'(MAX_DIGITS));
        offer_number(VALUE_MAX, COUNT_W'(1));
        offer_number(VALUE_MAX, '0);
        offer_number(VALUE_W'(5), COUNT_W'(1));
        offer_number(VALUE_W'(9), COUNT_W'(1));
        offer_number(VALUE_W'(10), COUNT_W'(1));
        offer_number(VALUE_W'(1000000000), COUNT_W'(9));
        offer_number(VALUE_W'(1000000000), COUNT_W'(MAX_DIGITS));
        offer_number(VALUE_W'(9999999), COUNT_W'(MAX_DIGITS));
        offer_number(VALUE_W'(1234567890), COUNT_W'(5));
        offer_number(VALUE_W'(999999999), COUNT_W'(MAX_DIGITS));
        offer_number(VALUE_W'(1), COUNT_W'(MAX_DIGITS));
    endtask

    // counts above the maximum fall back to ten characters
    task automatic test_saturated_counts();
        int c;
        for (c = MAX_DIGITS + 1; c <= 15; c++)
            offer_number(VALUE_MAX, COUNT_W'(c));
        offer_number(VALUE_W'(42), COUNT_W'(15));
        offer_number('0, COUNT_W'(15));
        offer_number(VALUE_W'(123456789), COUNT_W'(12));
    endtask

    // back-to-back items with neither side idling
    task automatic test_steady_stream();
        int n;
        steady = 1'b1;
        for (n = 0; n < 40; n++)
            offer_number(pick_value(), pick_count());
        steady = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_back_pressure();
        int n;
        steady = 1'b1;
        hold_requests++;
        for (n = 0; n < 16; n++)
            offer_number(pick_value(), COUNT_W'($urandom_range(MAX_DIGITS, 1)));
        steady = 1'b0;
    endtask

    task automatic test_random_items();
        int n;
        for (n = 0; n < 180; n++)
            offer_number(pick_value(), pick_count());
    endtask

    // reset, the tests in turn, then drain and verdict
    initial
    begin
        in_valid      = 1'b0;
        in_data       = '0;
        steady        = 1'b0;
        hold_requests = 0;
        // reset edge lands after time zero so the flops see it
        #1;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_saturated_counts();
        test_steady_stream();
        test_back_pressure();
        test_random_items();
        in_valid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
